### sv/stkh_pkg.sv
// ---------------------------------------------------------------------------
// Streaming top-k heap package
// Shared types for the controller and the datapath.
// ---------------------------------------------------------------------------
package stkh_pkg;

    typedef enum logic [2:0] {
        REG_KEEP_COUNT    = 3'd0,
        REG_MIN_ORDER     = 3'd1,
        REG_NULLS_ENABLED = 3'd2,
        REG_NULL_LEAD     = 3'd3,
        REG_NULL_VALUE    = 3'd4
    } cfg_index_t;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;
    localparam int KEEP_BITS      = 7;
    localparam int BIN_BITS       = 6;

    // Input word: one signed key.
    typedef struct packed {
        logic [63:0] key;
    } in_word_t;

    // Result word: verdict and the bin that holds the key.
    typedef struct packed {
        logic                accepted;
        logic [BIN_BITS-1:0] bin;
    } out_word_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INSERT,
        OP_RD_TOP,
        OP_CMP_TOP,
        OP_RD_UP,
        OP_UP_CMP,
        OP_RD_DOWN,
        OP_DOWN_CMP,
        OP_PLACE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic fill;      // heap not yet at k entries
        logic up_done;   // sift up stops at the current position
        logic down_done; // sift down stops at the current position
        logic reject;    // key ranks before the top key
    } status_t;

endpackage

### sv/stkh_stream_if.sv
// ---------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying a payload of type payload_t.
// ---------------------------------------------------------------------------
interface stkh_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/stkh_ctrl.sv
// ---------------------------------------------------------------------------
// Streaming top-k heap controller
// Sequences insert, reject test and sift steps of one word at a time.
// ---------------------------------------------------------------------------
module stkh_ctrl
    import stkh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_RD_TOP, S_CMP_TOP, S_RD_UP, S_UP_CMP,
        S_RD_DOWN, S_DOWN_CMP, S_PLACE, S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   emit;

    // The finished result moves to the output register once it is free.
    assign emit = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:    state_reg <= status.fill ? S_RD_UP : S_RD_TOP;
                S_RD_TOP:    state_reg <= S_CMP_TOP;
                S_CMP_TOP:   state_reg <= status.reject ? S_OUT : S_RD_DOWN;
                S_RD_UP:     state_reg <= S_UP_CMP;
                S_UP_CMP:    state_reg <= status.up_done ? S_PLACE : S_RD_UP;
                S_RD_DOWN:   state_reg <= S_DOWN_CMP;
                S_DOWN_CMP:  state_reg <= status.down_done ? S_PLACE : S_RD_DOWN;
                S_PLACE:     state_reg <= S_OUT;
                S_OUT:
                begin
                    if (emit)
                        state_reg <= S_IDLE;
                end
                default:     state_reg <= S_IDLE;
            endcase

            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_IDLE:      cmd.op = in_valid ? OP_LOAD : OP_NONE;
            S_DECIDE:    cmd.op = status.fill ? OP_INSERT : OP_NONE;
            S_RD_TOP:    cmd.op = OP_RD_TOP;
            S_CMP_TOP:   cmd.op = OP_CMP_TOP;
            S_RD_UP:     cmd.op = OP_RD_UP;
            S_UP_CMP:    cmd.op = OP_UP_CMP;
            S_RD_DOWN:   cmd.op = OP_RD_DOWN;
            S_DOWN_CMP:  cmd.op = OP_DOWN_CMP;
            S_PLACE:     cmd.op = OP_PLACE;
            S_OUT:       cmd.op = emit ? OP_EMIT : OP_NONE;
            default:     cmd.op = OP_NONE;
        endcase
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_out_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> out_valid)
        else $error("result not presented");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

endmodule

### sv/stkh_datapath.sv
// ---------------------------------------------------------------------------
// Streaming top-k heap datapath
// Configuration registers, heap bin and key memories, and the comparator.
// ---------------------------------------------------------------------------
module stkh_datapath
    import stkh_pkg::*;
#(
    parameter int MAX_KEEP = 64,
    parameter int KEY_BITS = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic [KEY_BITS-1:0]       in_key,
    input  cmd_t                      cmd,
    output status_t                   status,
    output logic                      res_accepted,
    output logic [BIN_BITS-1:0]       res_bin
);

    localparam int PW = $clog2(MAX_KEEP);
    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int IW = PW + 1;
    localparam int XW = PW + 2;

    logic [KEEP_BITS-1:0] keep_count_reg;
    logic                 min_order_reg;
    logic                 nulls_enabled_reg;
    logic                 null_lead_reg;
    logic [KEY_BITS-1:0]  null_value_reg;
    logic [CW-1:0]        count_reg;

    // Both memories are indexed by heap position.
    logic [PW-1:0]        bin_mem [MAX_KEEP];
    logic [KEY_BITS-1:0]  key_mem [MAX_KEEP];

    logic [KEY_BITS-1:0]  key_reg;       // key being placed
    logic [PW-1:0]        move_bin_reg;  // bin that travels with that key
    logic [IW-1:0]        pos_reg;       // free position the key would fill
    logic [KEY_BITS-1:0]  key_a_reg, key_b_reg;
    logic [PW-1:0]        bin_a_reg, bin_b_reg;
    logic                 has_r_reg, done_reg, acc_reg;
    logic [BIN_BITS-1:0]  bin_reg;
    logic                 res_acc_reg;
    logic [BIN_BITS-1:0]  res_bin_reg;

    function automatic logic ranks_ahead(input logic [KEY_BITS-1:0] a,
                                         input logic [KEY_BITS-1:0] b,
                                         input logic mo, input logic ne,
                                         input logic nl,
                                         input logic [KEY_BITS-1:0] nv);
        logic r;
        if (ne && nl && b == nv)       r = 1'b1;
        else if (ne && nl && a == nv)  r = 1'b0;
        else if (ne && !nl && a == nv) r = 1'b1;
        else if (ne && !nl && b == nv) r = 1'b0;
        else if (mo)                   r = $signed(a) < $signed(b);
        else                           r = $signed(a) > $signed(b);
        return r;
    endfunction

    logic [CW-1:0] k_eff;
    always_comb
    begin
        if (keep_count_reg == '0)
            k_eff = CW'(1);
        else if (32'(keep_count_reg) > MAX_KEEP)
            k_eff = CW'(MAX_KEEP);
        else
            k_eff = CW'(keep_count_reg);
    end

    logic [IW-1:0] parent;
    logic [XW-1:0] left, right;
    assign parent = (pos_reg - IW'(1)) >> 1;
    assign left   = {pos_reg, 1'b1};
    assign right  = left + XW'(1);

    // The key being placed sits in key_reg; memory reads land in the a and b
    // registers: the top or the parent in a, the children in a and b.
    logic                top_reject, up_stop, pick_r, down_stop;
    logic [KEY_BITS-1:0] key_c;
    logic [PW-1:0]       bin_c;
    assign top_reject = ranks_ahead(key_reg, key_a_reg, min_order_reg, nulls_enabled_reg,
                                    null_lead_reg, null_value_reg);
    assign up_stop    = done_reg || ranks_ahead(key_a_reg, key_reg, min_order_reg,
                                    nulls_enabled_reg, null_lead_reg, null_value_reg);
    assign pick_r     = has_r_reg && !ranks_ahead(key_a_reg, key_b_reg, min_order_reg,
                                    nulls_enabled_reg, null_lead_reg, null_value_reg);
    assign key_c      = pick_r ? key_b_reg : key_a_reg;
    assign bin_c      = pick_r ? bin_b_reg : bin_a_reg;
    assign down_stop  = done_reg || ranks_ahead(key_reg, key_c, min_order_reg,
                                    nulls_enabled_reg, null_lead_reg, null_value_reg);

    logic [PW-1:0] rd_addr_a, rd_addr_b;
    always_comb
    begin
        unique case (cmd.op)
            OP_RD_TOP:  rd_addr_a = '0;
            OP_RD_UP:   rd_addr_a = parent[PW-1:0];
            OP_RD_DOWN: rd_addr_a = left[PW-1:0];
            default:    rd_addr_a = '0;
        endcase
    end
    assign rd_addr_b = right[PW-1:0];

    // One write a cycle: a word moved into the free position, or the final
    // placement of the key itself.
    logic                mem_we;
    logic [KEY_BITS-1:0] wr_key;
    logic [PW-1:0]       wr_bin;
    always_comb
    begin
        mem_we = 1'b0;
        wr_key = key_reg;
        wr_bin = move_bin_reg;
        unique case (cmd.op)
            OP_UP_CMP:
            begin
                mem_we = !up_stop;
                wr_key = key_a_reg;
                wr_bin = bin_a_reg;
            end
            OP_DOWN_CMP:
            begin
                mem_we = !down_stop;
                wr_key = key_c;
                wr_bin = bin_c;
            end
            OP_PLACE:    mem_we = 1'b1;
            default:     ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[pos_reg[PW-1:0]] <= wr_key;
            bin_mem[pos_reg[PW-1:0]] <= wr_bin;
        end
        key_a_reg <= key_mem[rd_addr_a];
        bin_a_reg <= bin_mem[rd_addr_a];
        key_b_reg <= key_mem[rd_addr_b];
        bin_b_reg <= bin_mem[rd_addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg    <= KEEP_BITS'(64);
            min_order_reg     <= 1'b1;
            nulls_enabled_reg <= 1'b0;
            null_lead_reg     <= 1'b0;
            null_value_reg    <= '0;
            count_reg         <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_KEEP_COUNT:    keep_count_reg    <= cfg_data[KEEP_BITS-1:0];
                    REG_MIN_ORDER:     min_order_reg     <= cfg_data[0];
                    REG_NULLS_ENABLED: nulls_enabled_reg <= cfg_data[0];
                    REG_NULL_LEAD:     null_lead_reg     <= cfg_data[0];
                    REG_NULL_VALUE:    null_value_reg    <= cfg_data[KEY_BITS-1:0];
                    default: ;
                endcase
            end
            if (cmd.op == OP_INSERT)
                count_reg <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:     key_reg <= in_key;
            OP_INSERT:
            begin
                pos_reg      <= IW'(count_reg);
                move_bin_reg <= count_reg[PW-1:0];
                acc_reg      <= 1'b1;
                bin_reg      <= BIN_BITS'(count_reg);
            end
            OP_CMP_TOP:
            begin
                acc_reg      <= !top_reject;
                bin_reg      <= top_reject ? '0 : BIN_BITS'(bin_a_reg);
                move_bin_reg <= bin_a_reg;
                pos_reg      <= '0;
            end
            OP_RD_UP:    done_reg <= (pos_reg == '0);
            OP_UP_CMP:
            begin
                if (!up_stop)
                    pos_reg <= parent;
            end
            OP_RD_DOWN:
            begin
                done_reg  <= (left >= XW'(count_reg));
                has_r_reg <= (right < XW'(count_reg));
            end
            OP_DOWN_CMP:
            begin
                if (!down_stop)
                    pos_reg <= pick_r ? right[IW-1:0] : left[IW-1:0];
            end
            OP_EMIT:
            begin
                res_acc_reg <= acc_reg;
                res_bin_reg <= bin_reg;
            end
            default: ;
        endcase
    end

    assign status.fill      = count_reg < k_eff;
    assign status.up_done   = up_stop;
    assign status.down_done = down_stop;
    assign status.reject    = top_reject;
    assign res_accepted     = res_acc_reg;
    assign res_bin          = res_bin_reg;

endmodule

### sv/streaming_top_k_heap_top.sv
// ---------------------------------------------------------------------------
// Streaming top-k heap
// Keeps the best k signed keys of a stream in a binary heap.
// ---------------------------------------------------------------------------
// Use: each input word carries one key; each key gives exactly one result
// word with accepted and the bin that now holds the key (0 when rejected).
// The in channel is ready only while the controller is idle. A rejected key
// is read and compared only against the top key. A fill or a replace checks
// m heap levels, with one read and one compare step each and the move folded
// into the compare, where m runs from 1 up to log2(MAX_KEEP) + 1. The next
// key can be taken in the cycle in which the result of the last one shows.
// The result sits in an output register until out.ready; while it waits
// one more key is worked and then held in its last step with in.ready low.
// Reset clears the held count and sets the registers to k=64, min order,
// nulls off. Configuration writes go through cfg_write, cfg_index and
// cfg_data; the user must make them only while no key is in flight, as the
// block itself does not enforce it.
// ---------------------------------------------------------------------------
module streaming_top_k_heap_top
    import stkh_pkg::*;
#(
    parameter int MAX_KEEP = 64,
    parameter int KEY_BITS = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    stkh_stream_if.sink               in,
    stkh_stream_if.source             out
);

    cmd_t    cmd;
    status_t status;
    logic    res_accepted;
    logic [BIN_BITS-1:0] res_bin;

    stkh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    stkh_datapath #(
        .MAX_KEEP (MAX_KEEP),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_key       (in.data.key[KEY_BITS-1:0]),
        .cmd          (cmd),
        .status       (status),
        .res_accepted (res_accepted),
        .res_bin      (res_bin)
    );

    assign out.data.accepted = res_accepted;
    assign out.data.bin      = res_bin;

endmodule
